// ----- sv/moving_average_filter_unit_assert.svh -----
// assertion macros for the moving average filter unit
// no dependencies; included inside the top-level module body
`ifndef MOVING_AVERAGE_FILTER_UNIT_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MAF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving average filter: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define MAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving average filter: next-cycle check failed");

`endif

// ----- sv/mavg_pkg.sv -----
// shared constants and helpers for the moving average filter unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

    localparam int MAX_WINDOW      = 16;
    localparam int SAMPLE_BITS     = 12;
    localparam int WINDOW_AT_RESET = 3;
    localparam int CFG_BITS        = 5;

    localparam int POS_BITS   = $clog2(MAX_WINDOW);
    localparam int LEN_BITS   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CNT_BITS   = $clog2(SUM_BITS);
    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    // saturate a window write into 1..MAX_WINDOW
    function automatic logic [LEN_BITS-1:0] clamp_window(input logic [CFG_BITS-1:0] v);
        logic [LEN_BITS-1:0] res;
        if (v == '0) begin
            res = LEN_BITS'(1);
        end else if (int'(v) > MAX_WINDOW) begin
            res = LEN_BITS'(MAX_WINDOW);
        end else begin
            res = LEN_BITS'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/moving_average_filter_unit.sv -----
// moving average filter unit: ring of recent samples, running sum, bit-serial mean
// depends on mavg_pkg and moving_average_filter_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

// usage:
//   slave stream (i_s_axis_*) carries one sample per transaction in tdata[11:0].
//   master stream (o_m_axis_*) carries the truncated mean in tdata[11:0].
//   config channel (i_cfg_valid/o_cfg_ready/i_cfg_data) sets the window length,
//   saturated into 1..16; every write empties the window. write only when idle.
// sequence: an accepted sample updates the running sum, which is then divided
//   by the fill count in restoring division, one quotient bit per cycle; the
//   quotient then moves into the output register.
// samples: the bit-serial divider handles one sample at a time, so a new
//   sample is taken only after the last one's mean is handed over; tready is
//   high only while the divider is free.
// reset: window length 3, sum, write position and fill count cleared, output
//   empty. ring entries need no clearing: a slot not yet written since the last
//   clear is always one the fill count marks as empty, and reads as zero.
// stall: a finished mean waits in the output register while the receiver holds
//   tready low; the next sample is still taken, and its division waits at the
//   end until the output register is free.
module moving_average_filter_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // sample stream in, tdata: sample[11:0], zero padding above
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [mavg_pkg::TDATA_BITS-1:0] i_s_axis_tdata,
    // mean stream out, tdata: average[11:0], zero padding above
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic      [mavg_pkg::TDATA_BITS-1:0] o_m_axis_tdata,
    // window length write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mavg_pkg::CFG_BITS-1:0]   i_cfg_data
);
    import mavg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [LEN_BITS-1:0]    r_len, n_len;
    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic [LEN_BITS-1:0]    r_fill, n_fill;
    logic [SUM_BITS-1:0]    r_sum, n_sum;
    logic [SAMPLE_BITS-1:0] r_store [MAX_WINDOW];

    // divider: dividend shifts out the top while quotient bits enter the bottom
    logic [SUM_BITS-1:0]    r_quo, n_quo;
    logic [LEN_BITS-1:0]    r_rem, n_rem;
    logic [LEN_BITS-1:0]    r_div, n_div;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;

    logic                   r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_data, n_out_data;

    logic                   in_txn, cfg_txn, out_free;
    logic [SAMPLE_BITS-1:0] sample, oldest;
    logic [LEN_BITS:0]      trial;
    logic [LEN_BITS-1:0]    pos_inc;

    assign in_txn   = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_txn  = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign sample   = i_s_axis_tdata[SAMPLE_BITS-1:0];
    // slots beyond the fill count were not written since the last clear
    assign oldest   = (r_fill < r_len) ? '0 : r_store[r_pos];
    assign pos_inc  = LEN_BITS'(r_pos) + LEN_BITS'(1);
    assign trial    = {r_rem, r_quo[SUM_BITS-1]};

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_BITS'(r_out_data);

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_txn) begin
                    n_sum = r_sum - SUM_BITS'(oldest) + SUM_BITS'(sample);
                    n_pos = (pos_inc >= r_len) ? '0 : r_pos + POS_BITS'(1);
                    n_fill = (r_fill < r_len) ? r_fill + LEN_BITS'(1) : r_fill;
                    n_quo = n_sum;
                    n_div = n_fill;
                    n_rem = '0;
                    n_cnt = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (trial >= {1'b0, r_div}) begin
                    n_rem = LEN_BITS'(trial - {1'b0, r_div});
                    n_quo = {r_quo[SUM_BITS-2:0], 1'b1};
                end else begin
                    n_rem = trial[LEN_BITS-1:0];
                    n_quo = {r_quo[SUM_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(SUM_BITS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_quo[SAMPLE_BITS-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cfg_txn) begin
            n_len  = clamp_window(i_cfg_data);
            n_sum  = '0;
            n_pos  = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= LEN_BITS'(WINDOW_AT_RESET);
            r_pos       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_out_data <= n_out_data;
        if (in_txn) begin
            r_store[r_pos] <= sample;
        end
    end

`include "moving_average_filter_unit_assert.svh"

    `MAF_ASSERT_NEXT(a_accept_starts_div, i_clk, i_rst_n, in_txn && !cfg_txn, r_state == ST_DIV)
    `MAF_ASSERT_SAME(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= r_len)
    `MAF_ASSERT_SAME(a_pos_tracks_fill, i_clk, i_rst_n, r_fill < r_len, LEN_BITS'(r_pos) == r_fill)

endmodule

`default_nettype wire
